>>> rtl/core/qvr_pkg.sv
// Shared types and constants for the quaternion vector rotation block.
// No dependencies; imported by the matrix builder, the top level and the testbench.
package qvr_pkg;

    // Signed Q2.14 coefficient and signed Q16.16 vector component.
    typedef logic signed [15:0] q14_t;
    typedef logic signed [31:0] q16_t;

    // Quaternion as held in the configuration registers.
    typedef struct packed {
        q14_t s;
        q14_t i;
        q14_t j;
        q14_t k;
    } quat_t;

    // Rotation matrix, row then column.
    typedef q14_t mat_t [3][3];

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_QUAT_SCALAR = 2'd0;
    localparam logic [1:0] REG_QUAT_I      = 2'd1;
    localparam logic [1:0] REG_QUAT_J      = 2'd2;
    localparam logic [1:0] REG_QUAT_K      = 2'd3;

    // Reset quaternion: identity rotation.
    localparam q14_t ONE_Q14 = 16'sd16384;

    // Number of fraction bits dropped when a wide product is rounded.
    localparam int RND_SHIFT = 14;

endpackage

>>> rtl/core/qvr_matrix.sv
// Rotation matrix builder: registers the nine quaternion products, then forms,
// rounds, clamps and registers the matrix entries. Depends on qvr_pkg.
module qvr_matrix (
    input  logic          clk,
    input  qvr_pkg::quat_t quat,
    output qvr_pkg::mat_t  mat
);
    import qvr_pkg::*;

    localparam logic signed [35:0] ONE_Q28  = 36'sd268435456;
    localparam logic signed [35:0] HALF_Q14 = 36'sd8192;
    localparam logic signed [35:0] MAX_Q14  = 36'sd16384;
    localparam logic signed [35:0] MIN_Q14  = -36'sd16384;

    // Products of the quaternion parts, exact Q4.28.
    logic signed [31:0] aa_reg, bb_reg, cc_reg;
    logic signed [31:0] ab_reg, ac_reg, bc_reg;
    logic signed [31:0] sa_reg, sb_reg, sc_reg;

    // Rounded and clamped entries, and their register.
    mat_t mat_next;
    mat_t mat_reg;

    // Round to Q2.14 (half up) and clamp to [-1, 1].
    function automatic q14_t clamp_entry(input logic signed [35:0] v);
        logic signed [35:0] r;
        logic        [15:0] e;
        r = (v + HALF_Q14) >>> RND_SHIFT;
        if (r > MAX_Q14)
            e = MAX_Q14[15:0];
        else if (r < MIN_Q14)
            e = MIN_Q14[15:0];
        else
            e = r[15:0];
        return e;
    endfunction

    // The products follow the registers every cycle; no reset is needed.
    always_ff @(posedge clk)
    begin
        aa_reg <= quat.i * quat.i;
        bb_reg <= quat.j * quat.j;
        cc_reg <= quat.k * quat.k;
        ab_reg <= quat.i * quat.j;
        ac_reg <= quat.i * quat.k;
        bc_reg <= quat.j * quat.k;
        sa_reg <= quat.s * quat.i;
        sb_reg <= quat.s * quat.j;
        sc_reg <= quat.s * quat.k;
    end

    // Matrix entries from pairs of products.
    always_comb
    begin
        mat_next[0][0] = clamp_entry(ONE_Q28 - ((36'(bb_reg) + 36'(cc_reg)) <<< 1));
        mat_next[0][1] = clamp_entry((36'(ab_reg) - 36'(sc_reg)) <<< 1);
        mat_next[0][2] = clamp_entry((36'(sb_reg) + 36'(ac_reg)) <<< 1);
        mat_next[1][0] = clamp_entry((36'(ab_reg) + 36'(sc_reg)) <<< 1);
        mat_next[1][1] = clamp_entry(ONE_Q28 - ((36'(aa_reg) + 36'(cc_reg)) <<< 1));
        mat_next[1][2] = clamp_entry((36'(bc_reg) - 36'(sa_reg)) <<< 1);
        mat_next[2][0] = clamp_entry((36'(ac_reg) - 36'(sb_reg)) <<< 1);
        mat_next[2][1] = clamp_entry((36'(sa_reg) + 36'(bc_reg)) <<< 1);
        mat_next[2][2] = clamp_entry(ONE_Q28 - ((36'(aa_reg) + 36'(bb_reg)) <<< 1));
    end

    // The entries are registered so the vector multipliers start from flops.
    always_ff @(posedge clk)
    begin
        mat_reg <= mat_next;
    end

    assign mat = mat_reg;

endmodule

>>> rtl/core/quaternion_vector_rotation.sv
// Quaternion vector rotation: APB quaternion registers, stream in, stream out.
// An accepted input word moves through the input, product, sum and output registers.
// Four stages (input, products, sum, saturate); one word per cycle unless stalled.
// A stalled stage holds its word; empty stages ahead still take new words.
// Reset (rst_n low, asynchronous): quaternion 1,0,0,0 and all stages empty.
// Depends on qvr_pkg and qvr_matrix.
module quaternion_vector_rotation (
    input  logic         clk,
    input  logic         rst_n,
    // Configuration port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // Input stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,   // x_in [31:0], y_in [63:32], z_in [95:64]
    input  logic [0:0]   s_axis_tuser,   // kind [0]
    // Output stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [95:0]  m_axis_tdata    // x_out [31:0], y_out [63:32], z_out [95:64]
);
    import qvr_pkg::*;

    localparam logic signed [49:0] HALF_Q30 = 50'sd8192;
    localparam logic signed [35:0] MAX_Q16  = 36'sd2147483647;
    localparam logic signed [35:0] MIN_Q16  = -36'sd2147483648;

    quat_t quat_reg;
    mat_t  mat;

    logic               wr_en;
    logic               rdy1, rdy2, rdy3, rdy4;

    logic               s1_valid_reg;
    logic               s1_kind_reg;
    q16_t               s1_vec_reg [3];

    logic               s2_valid_reg;
    logic signed [47:0] s2_prod_reg [3][3];
    logic signed [47:0] prod_next [3][3];

    logic               s3_valid_reg;
    logic signed [49:0] s3_sum_reg [3];

    logic               out_valid_reg;
    logic        [95:0] out_data_reg;
    logic signed [35:0] shifted [3];
    logic        [31:0] sat_next [3];

    // Configuration registers.
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quat_reg.s <= ONE_Q14;
            quat_reg.i <= '0;
            quat_reg.j <= '0;
            quat_reg.k <= '0;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_QUAT_SCALAR: quat_reg.s <= pwdata[15:0];
                REG_QUAT_I:      quat_reg.i <= pwdata[15:0];
                REG_QUAT_J:      quat_reg.j <= pwdata[15:0];
                REG_QUAT_K:      quat_reg.k <= pwdata[15:0];
                default:         quat_reg   <= quat_reg;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        unique case (paddr[3:2])
            REG_QUAT_SCALAR: prdata = {16'b0, quat_reg.s};
            REG_QUAT_I:      prdata = {16'b0, quat_reg.i};
            REG_QUAT_J:      prdata = {16'b0, quat_reg.j};
            REG_QUAT_K:      prdata = {16'b0, quat_reg.k};
            default:         prdata = '0;
        endcase
    end

    // Matrix follows the registers through the product and entry registers of qvr_matrix.
    qvr_matrix u_matrix (
        .clk  (clk),
        .quat (quat_reg),
        .mat  (mat)
    );

    // A stage takes a word when it is empty or its word moves on.
    assign rdy4          = !out_valid_reg || m_axis_tready;
    assign rdy3          = !s3_valid_reg  || rdy4;
    assign rdy2          = !s2_valid_reg  || rdy3;
    assign rdy1          = !s1_valid_reg  || rdy2;
    assign s_axis_tready = rdy1;

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                s1_valid_reg <= s_axis_tvalid;
            if (rdy2)
                s2_valid_reg <= s1_valid_reg;
            if (rdy3)
                s3_valid_reg <= s2_valid_reg;
            if (rdy4)
                out_valid_reg <= s3_valid_reg;
        end
    end

    // Products of vector and selected matrix entries; kind 1 uses the transpose.
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                if (s1_kind_reg)
                    prod_next[r][c] = s1_vec_reg[c] * mat[c][r];
                else
                    prod_next[r][c] = s1_vec_reg[c] * mat[r][c];
            end
        end
    end

    // Drop 14 fraction bits and saturate to 32 bits.
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            shifted[r] = s3_sum_reg[r][49:14];
            if (shifted[r] > MAX_Q16)
                sat_next[r] = MAX_Q16[31:0];
            else if (shifted[r] < MIN_Q16)
                sat_next[r] = MIN_Q16[31:0];
            else
                sat_next[r] = shifted[r][31:0];
        end
    end

    // Stage payload registers.
    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            s1_kind_reg   <= s_axis_tuser[0];
            s1_vec_reg[0] <= s_axis_tdata[31:0];
            s1_vec_reg[1] <= s_axis_tdata[63:32];
            s1_vec_reg[2] <= s_axis_tdata[95:64];
        end
        if (rdy2)
            s2_prod_reg <= prod_next;
        if (rdy3)
        begin
            for (int r = 0; r < 3; r++)
                s3_sum_reg[r] <= 50'(s2_prod_reg[r][0]) + 50'(s2_prod_reg[r][1])
                               + 50'(s2_prod_reg[r][2]) + HALF_Q30;
        end
        if (rdy4)
        begin
            for (int r = 0; r < 3; r++)
                out_data_reg[32*r +: 32] <= sat_next[r];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

>>> rtl/core/qvr_checker.sv
// Port-level checks for quaternion_vector_rotation, bound to the top level.
// Depends on quaternion_vector_rotation's port list.
module qvr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [95:0] m_axis_tdata
);

    // Reset empties the output stage.
    assert property (@(posedge clk) !rst_n |=> !m_axis_tvalid)
        else $error("output word valid after a reset cycle");

    // An empty output stage lets every stage move, so input is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while output stage empty");

    // A ready sink keeps the whole pipeline moving.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while sink ready");

    // A stalled output word holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output word changed");

endmodule

bind quaternion_vector_rotation qvr_checker u_qvr_checker (.*);

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for quaternion_vector_rotation: APB writes set the
// quaternion, vector words stream in and rotated words are checked against a
// local fixed-point predictor. Depends on qvr_pkg and the block's RTL.
module tb_top;
    import qvr_pkg::*;

    // One input word: kind bit and a Q16.16 vector.
    typedef struct {
        logic kind;
        q16_t x;
        q16_t y;
        q16_t z;
    } vec_word_t;

    // One rotated word.
    typedef struct {
        q16_t x;
        q16_t y;
        q16_t z;
    } rot_word_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [3:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [95:0]  s_axis_tdata = '0;    // x_in [31:0], y_in [63:32], z_in [95:64]
    logic [0:0]   s_axis_tuser = '0;    // kind [0]
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [95:0]  m_axis_tdata;         // x_out [31:0], y_out [63:32], z_out [95:64]

    // Local copy of the quaternion registers, updated on each completed write.
    q14_t quat_copy [4] = '{ONE_Q14, 16'sd0, 16'sd0, 16'sd0};

    vec_word_t pending_vec [$];
    rot_word_t expected_rot [$];
    int        mismatch_count = 0;
    int        snd_idle_pct = 0;
    int        rcv_stall_pct = 0;

    quaternion_vector_rotation uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    // Round a Q4.28 value to Q2.14, half up, and clamp it to [-1, 1].
    function automatic longint matrix_entry(input longint v28);
        longint e;
        e = (v28 + 64'sd8192) >>> RND_SHIFT;
        if (e > 64'sd16384)
            e = 64'sd16384;
        if (e < -64'sd16384)
            e = -64'sd16384;
        return e;
    endfunction

    // Rotated vector from the current quaternion copy.
    function automatic rot_word_t rotate_vector(input vec_word_t w);
        longint    s, a, b, c;
        longint    m [3][3];
        longint    v [3];
        longint    acc;
        rot_word_t r;
        q16_t      comp [3];
        s = quat_copy[0];
        a = quat_copy[1];
        b = quat_copy[2];
        c = quat_copy[3];
        m[0][0] = matrix_entry((64'sd1 <<< 28) - 2 * (b * b + c * c));
        m[0][1] = matrix_entry(2 * (a * b - s * c));
        m[0][2] = matrix_entry(2 * (s * b + a * c));
        m[1][0] = matrix_entry(2 * (a * b + s * c));
        m[1][1] = matrix_entry((64'sd1 <<< 28) - 2 * (a * a + c * c));
        m[1][2] = matrix_entry(2 * (b * c - s * a));
        m[2][0] = matrix_entry(2 * (a * c - s * b));
        m[2][1] = matrix_entry(2 * (s * a + b * c));
        m[2][2] = matrix_entry((64'sd1 <<< 28) - 2 * (a * a + b * b));
        v[0] = w.x;
        v[1] = w.y;
        v[2] = w.z;
        for (int row = 0; row < 3; row++)
        begin
            acc = 0;
            for (int col = 0; col < 3; col++)
                acc += v[col] * (w.kind ? m[col][row] : m[row][col]);
            acc = (acc + 64'sd8192) >>> RND_SHIFT;
            if (acc > 64'sd2147483647)
                acc = 64'sd2147483647;
            if (acc < -64'sd2147483648)
                acc = -64'sd2147483648;
            comp[row] = acc[31:0];
        end
        r.x = comp[0];
        r.y = comp[1];
        r.z = comp[2];
        return r;
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        $display("mismatch %s at %0t", msg, $realtime);
    endtask

    // Input driver: offers the oldest pending word, idling at random, and
    // predicts the rotated word when one is accepted.
    always @(posedge clk)
    begin : vec_driver
        logic offer;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_rot.push_back(rotate_vector(pending_vec[0]));
                void'(pending_vec.pop_front());
            end
            if (s_axis_tvalid && !s_axis_tready)
                offer = 1'b1;
            else
                offer = (pending_vec.size() != 0) && ($urandom_range(99) >= snd_idle_pct);
            s_axis_tvalid <= offer;
            if (offer)
            begin
                s_axis_tdata <= {pending_vec[0].z, pending_vec[0].y, pending_vec[0].x};
                s_axis_tuser <= pending_vec[0].kind;
            end
        end
    end

    // Output monitor: compares each accepted word with the oldest prediction.
    always @(posedge clk)
    begin : rot_monitor
        rot_word_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_rot.size() == 0)
                    flag_mismatch($sformatf("unexpected output word %h", m_axis_tdata));
                else
                begin
                    want = expected_rot.pop_front();
                    if (m_axis_tdata[31:0] !== want.x)
                        flag_mismatch($sformatf("x_out: expected %h, got %h",
                                                want.x, m_axis_tdata[31:0]));
                    if (m_axis_tdata[63:32] !== want.y)
                        flag_mismatch($sformatf("y_out: expected %h, got %h",
                                                want.y, m_axis_tdata[63:32]));
                    if (m_axis_tdata[95:64] !== want.z)
                        flag_mismatch($sformatf("z_out: expected %h, got %h",
                                                want.z, m_axis_tdata[95:64]));
                end
            end
            m_axis_tready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    // One APB write: setup cycle, then access cycle; the upper data bits are noise.
    task automatic apb_write(input logic [1:0] reg_idx, input q14_t value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= {16'($urandom()), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        quat_copy[reg_idx] = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_quat(input q14_t s, input q14_t i, input q14_t j, input q14_t k);
        apb_write(REG_QUAT_SCALAR, s);
        apb_write(REG_QUAT_I, i);
        apb_write(REG_QUAT_J, j);
        apb_write(REG_QUAT_K, k);
        @(negedge clk);
    endtask

    // Wait until no word is pending or in flight.
    task automatic drain();
        while (pending_vec.size() != 0 || expected_rot.size() != 0)
            @(negedge clk);
    endtask

    task automatic push_vec(input logic kind, input q16_t x, input q16_t y, input q16_t z);
        vec_word_t w;
        w.kind = kind;
        w.x = x;
        w.y = y;
        w.z = z;
        pending_vec.push_back(w);
    endtask

    // Vector component: full range, small or moderate magnitude, or an extreme.
    function automatic q16_t rand_comp();
        case ($urandom_range(3))
            0: return q16_t'($urandom());
            1: return q16_t'($signed($urandom_range(32'h0003_FFFF)) - 32'sh0002_0000);
            2: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: return q16_t'($signed($urandom_range(32'h00FF_FFFF)) - 32'sh0080_0000);
        endcase
    endfunction

    function automatic real rand_unit();
        return $urandom_range(20000) / 10000.0 - 1.0;
    endfunction

    function automatic q14_t to_q14(input real v);
        return q14_t'($rtoi(v * 16384.0 + ((v >= 0.0) ? 0.5 : -0.5)));
    endfunction

    // Random unit quaternion, falling back to identity when nearly zero.
    task automatic write_unit_quat();
        real a, b, c, d, n;
        a = rand_unit();
        b = rand_unit();
        c = rand_unit();
        d = rand_unit();
        n = $sqrt(a * a + b * b + c * c + d * d);
        if (n < 0.01)
            write_quat(ONE_Q14, 16'sd0, 16'sd0, 16'sd0);
        else
            write_quat(to_q14(a / n), to_q14(b / n), to_q14(c / n), to_q14(d / n));
    endtask

    function automatic q14_t rand_in_range();
        return q14_t'($signed($urandom_range(32768)) - 32'sd16384);
    endfunction

    // Run limit.
    initial
    begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Stimulus sequence.
    initial
    begin
        int n_half;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Identity rotation after reset: extremes and unit vectors.
        push_vec(1'b0, 32'sd0, 32'sd0, 32'sd0);
        push_vec(1'b0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        push_vec(1'b1, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
        push_vec(1'b0, 32'sh0001_0000, 32'shFFFF_0000, 32'sd1);
        push_vec(1'b1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'shFFFF_FFFF);
        push_vec(1'b0, 32'shFFFF_FFFF, 32'sd1, 32'sh8000_0000);
        drain();

        // Quarter turn about z: forward and inverse differ, rounding on odd LSBs.
        write_quat(16'sd11585, 16'sd0, 16'sd0, 16'sd11585);
        push_vec(1'b0, 32'sh0001_0000, 32'sd0, 32'sd0);
        push_vec(1'b1, 32'sh0001_0000, 32'sd0, 32'sd0);
        push_vec(1'b0, 32'sd1, 32'sd3, 32'sd5);
        push_vec(1'b1, 32'shFFFF_FFFF, 32'shFFFF_FFFD, 32'sd7);
        push_vec(1'b0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000);
        push_vec(1'b1, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        drain();

        // Register values beyond one: entries clamp and outputs saturate.
        write_quat(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        push_vec(1'b0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        push_vec(1'b1, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
        push_vec(1'b0, 32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000);
        drain();
        write_quat(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        push_vec(1'b0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
        push_vec(1'b1, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
        push_vec(1'b0, 32'sh0001_0000, 32'sd0, 32'shFFFF_0000);
        drain();

        // Non-unit quaternion at half scale: no normalization; the matrix stays identity.
        write_quat(16'sd8192, 16'sd0, 16'sd0, 16'sd0);
        push_vec(1'b0, 32'sh0001_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
        push_vec(1'b1, 32'sh0001_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
        drain();

        // Random phases, each with its own quaternion and one of four idling patterns.
        for (int p = 0; p < 8; p++)
        begin
            case (p % 4)
                0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
                1: begin snd_idle_pct = 81; rcv_stall_pct = 0;  end
                2: begin snd_idle_pct = 0;  rcv_stall_pct = 81; end
                default: begin snd_idle_pct = 9; rcv_stall_pct = 9; end
            endcase
            case (p)
                0: write_quat(16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384);
                1: write_quat(-16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384);
                3: write_quat(rand_in_range(), rand_in_range(), rand_in_range(),
                              rand_in_range());
                5: write_quat(q14_t'($urandom()), q14_t'($urandom()), q14_t'($urandom()),
                              q14_t'($urandom()));
                7: write_quat(16'sd0, 16'sd0, 16'sd0, 16'sd0);
                default: write_unit_quat();
            endcase
            n_half = 110;
            for (int h = 0; h < 2; h++)
            begin
                for (int n = 0; n < n_half; n++)
                    push_vec(1'($urandom_range(1)), rand_comp(), rand_comp(), rand_comp());
                // The sender holds off until the pipeline has emptied.
                drain();
            end
        end

        drain();
        repeat (12) @(posedge clk);
        if (mismatch_count == 0 && expected_rot.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> quaternion_vector_rotation.f
rtl/core/qvr_pkg.sv
rtl/core/qvr_matrix.sv
rtl/core/quaternion_vector_rotation.sv
rtl/core/qvr_checker.sv
tb/tb_top.sv
